// ===== hdl/modifier_key_chord_remapper_top_defines.svh =====
// Assertion macros for the modifier key chord remapper.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MODIFIER_KEY_CHORD_REMAPPER_TOP_DEFINES_SVH
`define MODIFIER_KEY_CHORD_REMAPPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MKCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkcr assertion failed");
`define MKCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkcr assertion failed");
`else
`define MKCR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MKCR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/mkcr_pkg.sv =====
// Shared types, event codes and helper functions for the modifier key chord remapper.
// No dependencies; used by the controller, the datapath and the top level.
package mkcr_pkg;

    localparam logic [15:0] T_SYN    = 16'd0;
    localparam logic [15:0] T_KEY    = 16'd1;
    localparam logic [15:0] T_MSC    = 16'd4;
    localparam logic [15:0] C_SCAN   = 16'd4;
    localparam logic [15:0] K_LMETA  = 16'd125;
    localparam logic [15:0] K_RMETA  = 16'd126;
    localparam logic [15:0] K_X      = 16'd45;
    localparam logic [15:0] K_C      = 16'd46;
    localparam logic [15:0] K_V      = 16'd47;
    localparam logic [15:0] K_DEL    = 16'd111;
    localparam logic [15:0] K_INS    = 16'd110;
    localparam logic [7:0]  B_LCTRL  = 8'h02;
    localparam logic [7:0]  B_LMETA  = 8'h04;
    localparam logic [7:0]  B_LSHIFT = 8'h08;
    localparam logic [7:0]  B_RMETA  = 8'h40;
    localparam logic [31:0] V_UP     = 32'd0;
    localparam logic [31:0] V_DOWN   = 32'd1;
    localparam logic [31:0] V_REP    = 32'd2;

    // Key code of each modifier bit, lowest bit first.
    localparam logic [15:0] BIT_KEY [8] = '{
        16'd56, 16'd29, 16'd125, 16'd42, 16'd100, 16'd97, 16'd126, 16'd54
    };

    typedef enum logic [2:0] {
        WANT_HOLD,
        WANT_SEEN_BIT,
        WANT_SEEN,
        WANT_CHORD,
        WANT_SAVED
    } t_want_sel;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_PASS,
        EMIT_MOD,
        EMIT_SYNC,
        EMIT_CHORD_DN,
        EMIT_CHORD_UP
    } t_emit_sel;

    typedef struct packed {
        logic      load;
        t_want_sel want_sel;
        logic      save_sent;
        logic      set_chord;
        logic      clr_chord;
        t_emit_sel emit;
        logic      last;
        logic      apply_mod;
        logic      apply_final;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic is_key;
        logic is_scan;
        logic is_meta;
        logic is_xcv;
        logic is_mod;
        logic meta_held;
        logic val_down;
        logic val_up;
        logic val_rep;
        logic meta_force;
        logic ord_force;
        logic sent_has_bit;
        logic diff_nz;
        logic diff_rest_nz;
    } t_status;

    function automatic logic [7:0] mod_bit(input logic [15:0] code);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (BIT_KEY[i] == code) begin
                b[i] = 1'b1;
            end
        end
        return b;
    endfunction

    function automatic logic [7:0] track_mods(input logic [7:0] mods, input logic [7:0] b,
                                              input logic [31:0] v);
        logic [7:0] r;
        r = mods;
        if (b != 8'h00) begin
            if (v == V_UP) begin
                r = mods & ~b;
            end else if (v == V_DOWN) begin
                r = mods | b;
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] low_index(input logic [7:0] d);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (d[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/mkcr_datapath.sv =====
// Datapath of the modifier key chord remapper: event latch, modifier sets and output register.
// Depends on mkcr_pkg and on the assertion macros in modifier_key_chord_remapper_top_defines.svh.
`include "modifier_key_chord_remapper_top_defines.svh"

module mkcr_datapath
    import mkcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_ev_type,
    input  logic [15:0]        i_ev_code,
    input  logic signed [31:0] i_ev_value,
    input  logic               i_out_ready,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [15:0]        o_out_type,
    output logic [15:0]        o_out_code,
    output logic signed [31:0] o_out_value,
    output logic               o_last_of_run
);

    logic [15:0] r_type;
    logic [15:0] r_code;
    logic [31:0] r_value;
    logic [7:0]  r_seen, n_seen;
    logic [7:0]  r_sent, n_sent;
    logic        r_chord, n_chord;
    logic [7:0]  r_want, n_want;
    logic [7:0]  r_saved;
    logic        r_out_valid;
    logic [15:0] r_out_type, n_out_type;
    logic [15:0] r_out_code, n_out_code;
    logic [31:0] r_out_value, n_out_value;
    logic        r_out_last;

    logic [7:0]  w_bit;
    logic [7:0]  w_diff;
    logic [7:0]  w_low;
    logic [2:0]  w_idx;
    logic [15:0] w_chord_key;
    logic [7:0]  w_chord_mods;

    assign w_bit        = mod_bit(r_code);
    assign w_diff       = r_sent ^ r_want;
    assign w_low        = w_diff & (~w_diff + 8'd1);
    assign w_idx        = low_index(w_diff);
    assign w_chord_key  = (r_code == K_X) ? K_DEL : K_INS;
    assign w_chord_mods = (r_code == K_C) ? B_LCTRL : B_LSHIFT;

    always_comb begin
        o_status.slot_free    = !r_out_valid || i_out_ready;
        o_status.is_key       = (r_type == T_KEY);
        o_status.is_scan      = (r_type == T_MSC) && (r_code == C_SCAN);
        o_status.is_meta      = (r_code == K_LMETA) || (r_code == K_RMETA);
        o_status.is_xcv       = (r_code == K_X) || (r_code == K_C) || (r_code == K_V);
        o_status.is_mod       = (w_bit != 8'h00);
        o_status.meta_held    = ((r_seen & (B_LMETA | B_RMETA)) != 8'h00);
        o_status.val_down     = (r_value == V_DOWN);
        o_status.val_up       = (r_value == V_UP);
        o_status.val_rep      = (r_value == V_REP);
        o_status.meta_force   = !r_chord && ((r_seen | w_bit) != r_sent);
        o_status.ord_force    = (r_seen != r_sent);
        o_status.sent_has_bit = ((r_sent & w_bit) != 8'h00);
        o_status.diff_nz      = (w_diff != 8'h00);
        o_status.diff_rest_nz = ((w_diff & ~w_low) != 8'h00);
    end

    always_comb begin
        n_seen  = r_seen;
        n_sent  = r_sent;
        n_chord = r_chord;
        n_want  = r_want;
        if (i_cmd.load && (i_ev_type == T_KEY)) begin
            n_seen = track_mods(r_seen, mod_bit(i_ev_code), i_ev_value);
        end
        if (i_cmd.apply_mod) begin
            n_sent = r_sent ^ w_low;
        end else if (i_cmd.apply_final && (r_type == T_KEY)) begin
            n_sent = track_mods(r_sent, w_bit, r_value);
        end
        if (i_cmd.set_chord) begin
            n_chord = 1'b1;
        end else if (i_cmd.clr_chord) begin
            n_chord = 1'b0;
        end
        unique case (i_cmd.want_sel)
            WANT_HOLD:     n_want = r_want;
            WANT_SEEN_BIT: n_want = r_seen | w_bit;
            WANT_SEEN:     n_want = r_seen;
            WANT_CHORD:    n_want = w_chord_mods;
            WANT_SAVED:    n_want = r_saved;
            default:       n_want = r_want;
        endcase
    end

    always_comb begin
        n_out_type  = T_SYN;
        n_out_code  = 16'd0;
        n_out_value = 32'd0;
        unique case (i_cmd.emit)
            EMIT_PASS: begin
                n_out_type  = r_type;
                n_out_code  = r_code;
                n_out_value = r_value;
            end
            EMIT_MOD: begin
                n_out_type  = T_KEY;
                n_out_code  = BIT_KEY[w_idx];
                n_out_value = r_want[w_idx] ? V_DOWN : V_UP;
            end
            EMIT_CHORD_DN: begin
                n_out_type  = T_KEY;
                n_out_code  = w_chord_key;
                n_out_value = V_DOWN;
            end
            EMIT_CHORD_UP: begin
                n_out_type  = T_KEY;
                n_out_code  = w_chord_key;
                n_out_value = V_UP;
            end
            EMIT_NONE, EMIT_SYNC: begin
                n_out_type  = T_SYN;
                n_out_code  = 16'd0;
                n_out_value = 32'd0;
            end
            default: begin
                n_out_type  = T_SYN;
                n_out_code  = 16'd0;
                n_out_value = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 8'h00;
            r_sent      <= 8'h00;
            r_chord     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_sent  <= n_sent;
            r_chord <= n_chord;
            if (i_cmd.emit != EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        if (i_cmd.load) begin
            r_type  <= i_ev_type;
            r_code  <= i_ev_code;
            r_value <= i_ev_value;
        end
        if (i_cmd.save_sent) begin
            r_saved <= r_sent;
        end
        if (i_cmd.emit != EMIT_NONE) begin
            r_out_type  <= n_out_type;
            r_out_code  <= n_out_code;
            r_out_value <= n_out_value;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_type    = r_out_type;
    assign o_out_code    = r_out_code;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;

    `MKCR_ASSERT_IMP(a_emit_needs_slot, i_clk, i_rst_n, i_cmd.emit != EMIT_NONE, !r_out_valid || i_out_ready)
    `MKCR_ASSERT_IMP(a_mod_step_has_diff, i_clk, i_rst_n, i_cmd.emit == EMIT_MOD, w_diff != 8'h00)
    `MKCR_ASSERT_IMP(a_chord_flag_set, i_clk, i_rst_n, i_cmd.emit == EMIT_CHORD_DN, r_chord)
    `MKCR_ASSERT_NXT(a_mod_step_clears_bit, i_clk, i_rst_n, i_cmd.apply_mod && (i_cmd.want_sel == WANT_HOLD), $countones(w_diff) == $countones($past(w_diff)) - 1)

endmodule

// ===== hdl/mkcr_ctrl.sv =====
// Controller state machine of the modifier key chord remapper.
// Depends on mkcr_pkg; drives the datapath through t_cmd and reads t_status.
module mkcr_ctrl
    import mkcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FORCE_KEY,
        ST_FORCE_SYN,
        ST_CHORD_DN,
        ST_CHORD_SYN1,
        ST_CHORD_UP,
        ST_CHORD_SYN2,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        MODE_FINAL,
        MODE_CHORD,
        MODE_RESTORE
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '{load: 1'b0, want_sel: WANT_HOLD, save_sent: 1'b0, set_chord: 1'b0,
                    clr_chord: 1'b0, emit: EMIT_NONE, last: 1'b0, apply_mod: 1'b0,
                    apply_final: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_status.is_key) begin
                    n_state = i_status.is_scan ? ST_IDLE : ST_FINAL;
                end else if (i_status.is_meta) begin
                    if (i_status.val_down) begin
                        o_cmd.clr_chord = 1'b1;
                        n_state         = ST_IDLE;
                    end else if (i_status.val_up && i_status.meta_force) begin
                        o_cmd.want_sel = WANT_SEEN_BIT;
                        n_mode         = MODE_FINAL;
                        n_state        = ST_FORCE_KEY;
                    end else if (i_status.val_up || i_status.val_rep) begin
                        n_state = i_status.sent_has_bit ? ST_FINAL : ST_IDLE;
                    end else begin
                        n_state = ST_FINAL;
                    end
                end else if (i_status.is_xcv) begin
                    if (!i_status.meta_held) begin
                        n_state = ST_FINAL;
                    end else if (i_status.val_down) begin
                        o_cmd.save_sent = 1'b1;
                        o_cmd.set_chord = 1'b1;
                        o_cmd.want_sel  = WANT_CHORD;
                        n_mode          = MODE_CHORD;
                        n_state         = ST_FORCE_KEY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (!i_status.is_mod && i_status.ord_force) begin
                    o_cmd.want_sel = WANT_SEEN;
                    n_mode         = MODE_FINAL;
                    n_state        = ST_FORCE_KEY;
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_FORCE_KEY: begin
                if (!i_status.diff_nz) begin
                    unique case (r_mode)
                        MODE_CHORD:   n_state = ST_CHORD_DN;
                        MODE_FINAL:   n_state = ST_FINAL;
                        MODE_RESTORE: n_state = ST_IDLE;
                        default:      n_state = ST_IDLE;
                    endcase
                end else if (i_status.slot_free) begin
                    o_cmd.emit = EMIT_MOD;
                    n_state    = ST_FORCE_SYN;
                end
            end
            ST_FORCE_SYN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit      = EMIT_SYNC;
                    o_cmd.apply_mod = 1'b1;
                    o_cmd.last      = (r_mode == MODE_RESTORE) && !i_status.diff_rest_nz;
                    if (i_status.diff_rest_nz) begin
                        n_state = ST_FORCE_KEY;
                    end else begin
                        unique case (r_mode)
                            MODE_CHORD:   n_state = ST_CHORD_DN;
                            MODE_FINAL:   n_state = ST_FINAL;
                            MODE_RESTORE: n_state = ST_IDLE;
                            default:      n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_CHORD_DN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit     = EMIT_CHORD_DN;
                    o_cmd.want_sel = WANT_SAVED;
                    n_state        = ST_CHORD_SYN1;
                end
            end
            ST_CHORD_SYN1: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = EMIT_SYNC;
                    n_state    = ST_CHORD_UP;
                end
            end
            ST_CHORD_UP: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = EMIT_CHORD_UP;
                    n_state    = ST_CHORD_SYN2;
                end
            end
            ST_CHORD_SYN2: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = EMIT_SYNC;
                    o_cmd.last = !i_status.diff_nz;
                    n_mode     = MODE_RESTORE;
                    n_state    = i_status.diff_nz ? ST_FORCE_KEY : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (i_status.slot_free) begin
                    o_cmd.emit        = EMIT_PASS;
                    o_cmd.last        = 1'b1;
                    o_cmd.apply_final = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MODE_FINAL;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== hdl/modifier_key_chord_remapper_top.sv =====
// Top level of the modifier key chord remapper: controller plus datapath.
// Depends on mkcr_pkg, mkcr_ctrl and mkcr_datapath.

// One input event is taken at a time. After acceptance the controller classifies it in
// ST_DECIDE, then sends one result beat per cycle while the output side is ready. The
// number of beats for a key that first brings the sent modifiers in line, or for a meta
// chord, is set by the number of modifier changes the sequencer must emit, one key beat
// and one sync beat per changed bit. The result register lets the last beat wait while
// the next event is taken.
module modifier_key_chord_remapper_top
    import mkcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_ev_type,
    input  logic [15:0]        i_ev_code,
    input  logic signed [31:0] i_ev_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_out_type,
    output logic [15:0]        o_out_code,
    output logic signed [31:0] o_out_value,
    output logic               o_last_of_run
);

    t_cmd    w_cmd;
    t_status w_status;

    mkcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mkcr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev_type     (i_ev_type),
        .i_ev_code     (i_ev_code),
        .i_ev_value    (i_ev_value),
        .i_out_ready   (i_out_ready),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .o_out_type    (o_out_type),
        .o_out_code    (o_out_code),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== dv/modifier_key_chord_remapper_top_test.sv =====
// Self-checking testbench for modifier_key_chord_remapper_top: directed and random event streams.
// Expected beats come from a behavioural predictor of the remapper kept inside this file.
// Depends on mkcr_pkg and the RTL of the remapper only.
module modifier_key_chord_remapper_top_test
    import mkcr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUN_BEATS = 36;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 48;
    localparam int ITEMS_PER_PHASE = 95;

    localparam logic [15:0] MSC_RAW    = 16'd3;
    localparam logic [15:0] KEY_LALT   = 16'd56;
    localparam logic [15:0] KEY_LCTRL  = 16'd29;
    localparam logic [15:0] KEY_LSHIFT = 16'd42;
    localparam logic [15:0] KEY_RALT   = 16'd100;
    localparam logic [15:0] KEY_RCTRL  = 16'd97;
    localparam logic [15:0] KEY_RSHIFT = 16'd54;
    localparam logic [15:0] KEY_A      = 16'd30;
    localparam logic [15:0] KEY_B      = 16'd48;
    localparam logic [15:0] KEY_Q      = 16'd16;

    localparam int POOL_SIZE = 14;
    localparam logic [15:0] KEY_POOL [POOL_SIZE] = '{
        K_LMETA, K_RMETA, K_X, K_C, K_V, KEY_LALT, KEY_LCTRL,
        KEY_LSHIFT, KEY_RALT, KEY_RCTRL, KEY_RSHIFT, KEY_A, KEY_B, KEY_Q
    };

    typedef struct packed {
        logic [15:0] typ;
        logic [15:0] code;
        logic [31:0] value;
        logic        last;
    } t_ev_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_ev_type = '0;
    logic [15:0]        i_ev_code = '0;
    logic signed [31:0] i_ev_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [15:0]        o_out_type;
    logic [15:0]        o_out_code;
    logic signed [31:0] o_out_value;
    logic               o_last_of_run;

    logic [7:0]  mods_held;
    logic [7:0]  mods_issued;
    logic        chord_done;
    t_ev_beat    run_beats [MAX_RUN_BEATS];
    int          run_len;
    t_ev_beat    awaited_beats [$];
    int          fault_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 26;
    int          recv_idle_pct = 48;
    bit [POOL_SIZE-1:0] key_down;

    modifier_key_chord_remapper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ev_type     (i_ev_type),
        .i_ev_code     (i_ev_code),
        .i_ev_value    (i_ev_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_type    (o_out_type),
        .o_out_code    (o_out_code),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("modifier_key_chord_remapper_top_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] modifier_mask(input logic [15:0] code);
        logic [7:0] m;
        m = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (BIT_KEY[i] == code) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] apply_key(input logic [7:0] mods, input logic [7:0] m,
                                             input logic [31:0] v);
        if (m == 8'h00) begin
            return mods;
        end
        if (v == V_UP) begin
            return mods & ~m;
        end
        if (v == V_DOWN) begin
            return mods | m;
        end
        return mods;
    endfunction

    function automatic void add_beat(input logic [15:0] t, input logic [15:0] c,
                                     input logic [31:0] v);
        if (run_len < MAX_RUN_BEATS) begin
            run_beats[run_len] = '{typ: t, code: c, value: v, last: 1'b0};
            run_len++;
        end
    endfunction

    function automatic void add_key_with_sync(input logic [15:0] c, input logic [31:0] v);
        add_beat(T_KEY, c, v);
        add_beat(T_SYN, 16'd0, 32'd0);
    endfunction

    function automatic void steer_sent_mods(input logic [7:0] want);
        for (int i = 0; i < 8; i++) begin
            if (mods_issued[i] != want[i]) begin
                add_key_with_sync(BIT_KEY[i], want[i] ? V_DOWN : V_UP);
                mods_issued[i] = want[i];
            end
        end
    endfunction

    function automatic void predict_remap(input logic [15:0] t, input logic [15:0] c,
                                          input logic [31:0] v);
        logic [7:0] m;
        logic [7:0] want;
        logic [7:0] saved;
        logic       pass;
        run_len = 0;
        if (t == T_MSC && c == C_SCAN) begin
            return;
        end
        if (t != T_KEY) begin
            add_beat(t, c, v);
        end else begin
            m = modifier_mask(c);
            mods_held = apply_key(mods_held, m, v);
            pass = 1'b1;
            if (c == K_LMETA || c == K_RMETA) begin
                if (v == V_DOWN) begin
                    chord_done = 1'b0;
                    pass = 1'b0;
                end else if (v == V_UP || v == V_REP) begin
                    if (v == V_UP) begin
                        want = mods_held | m;
                        if (!chord_done && want != mods_issued) begin
                            steer_sent_mods(want);
                        end
                    end
                    if ((mods_issued & m) == 8'h00) begin
                        pass = 1'b0;
                    end
                end
            end else if (c == K_X || c == K_C || c == K_V) begin
                if ((mods_held & (B_LMETA | B_RMETA)) != 8'h00) begin
                    pass = 1'b0;
                    if (v == V_DOWN) begin
                        saved = mods_issued;
                        chord_done = 1'b1;
                        steer_sent_mods(c == K_C ? B_LCTRL : B_LSHIFT);
                        add_key_with_sync(c == K_X ? K_DEL : K_INS, V_DOWN);
                        add_key_with_sync(c == K_X ? K_DEL : K_INS, V_UP);
                        steer_sent_mods(saved);
                    end
                end
            end else if (m == 8'h00 && mods_held != mods_issued) begin
                steer_sent_mods(mods_held);
            end
            if (pass) begin
                add_beat(t, c, v);
                mods_issued = apply_key(mods_issued, m, v);
            end
        end
        for (int i = 0; i < run_len; i++) begin
            if (i == run_len - 1) begin
                run_beats[i].last = 1'b1;
            end
            awaited_beats.push_back(run_beats[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_ev_beat want_beat;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_beats.size() == 0) begin
                fault_count <= fault_count + 1;
                if (fault_count < 10) begin
                    $display("unexpected beat: type %h code %h value %h last %b",
                             o_out_type, o_out_code, o_out_value, o_last_of_run);
                end
            end else begin
                want_beat = awaited_beats.pop_front();
                if (o_out_type !== want_beat.typ || o_out_code !== want_beat.code ||
                    o_out_value !== want_beat.value || o_last_of_run !== want_beat.last) begin
                    fault_count <= fault_count + 1;
                    if (fault_count < 10) begin
                        $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                                 want_beat.typ, want_beat.code, want_beat.value,
                                 want_beat.last, o_out_type, o_out_code, o_out_value,
                                 o_last_of_run);
                    end
                end
            end
        end
    end

    task automatic send_event(input logic [15:0] t, input logic [15:0] c, input logic [31:0] v);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ev_type  <= t;
        i_ev_code  <= c;
        i_ev_value <= v;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
        predict_remap(t, c, v);
    endtask

    task automatic test_non_key_events();
        send_event(T_SYN, 16'd0, 32'd0);
        send_event(T_MSC, C_SCAN, 32'h0000_001e);
        send_event(T_MSC, MSC_RAW, 32'h7fff_ffff);
        send_event(16'hffff, 16'hffff, 32'h8000_0000);
    endtask

    task automatic test_modifier_catch_up();
        send_event(T_KEY, KEY_LSHIFT, V_DOWN);
        send_event(T_KEY, K_LMETA, V_DOWN);
        send_event(T_KEY, KEY_A, 32'hffff_ffff);
        send_event(T_KEY, K_LMETA, V_UP);
        send_event(T_KEY, KEY_LSHIFT, V_UP);
    endtask

    task automatic test_meta_tap();
        send_event(T_KEY, K_RMETA, V_DOWN);
        send_event(T_KEY, K_RMETA, V_REP);
        send_event(T_KEY, K_RMETA, V_UP);
    endtask

    task automatic test_chords();
        send_event(T_KEY, K_LMETA, V_DOWN);
        send_event(T_KEY, K_X, V_DOWN);
        send_event(T_KEY, K_C, V_DOWN);
        send_event(T_KEY, K_LMETA, 32'd5);
        send_event(T_KEY, K_V, 32'd7);
        send_event(T_KEY, K_V, V_DOWN);
        send_event(T_KEY, K_LMETA, V_UP);
    endtask

    // Every modifier but left shift goes out first, so the chord must flip all eight.
    task automatic test_longest_chord();
        send_event(T_KEY, KEY_LALT, V_DOWN);
        send_event(T_KEY, KEY_LCTRL, V_DOWN);
        send_event(T_KEY, KEY_RALT, V_DOWN);
        send_event(T_KEY, KEY_RCTRL, V_DOWN);
        send_event(T_KEY, KEY_RSHIFT, V_DOWN);
        send_event(T_KEY, K_LMETA, V_DOWN);
        send_event(T_KEY, K_RMETA, V_DOWN);
        send_event(T_KEY, KEY_A, V_DOWN);
        send_event(T_KEY, K_X, V_DOWN);
    endtask

    task automatic test_random_traffic(input int n_items);
        int done;
        int pick;
        int idx;
        int roll;
        logic [15:0] t;
        logic [15:0] c;
        logic [31:0] v;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                idx = $urandom_range(POOL_SIZE - 1);
                t = T_KEY;
                c = KEY_POOL[idx];
                roll = $urandom_range(99);
                if (roll < 85) begin
                    v = key_down[idx] ? V_UP : V_DOWN;
                    key_down[idx] = ~key_down[idx];
                end else if (roll < 93) begin
                    v = V_REP;
                end else begin
                    v = $urandom;
                end
            end else if (pick < 78) begin
                t = T_SYN;
                c = 16'd0;
                v = 32'd0;
            end else if (pick < 84) begin
                t = T_MSC;
                c = C_SCAN;
                v = $urandom;
            end else if (pick < 90) begin
                t = T_MSC;
                c = 16'($urandom_range(65535));
                v = $urandom;
            end else if (pick < 95) begin
                t = T_KEY;
                c = 16'($urandom_range(65535));
                v = ($urandom_range(1) == 1) ? V_DOWN : V_UP;
            end else begin
                t = 16'($urandom_range(65535));
                c = 16'($urandom_range(65535));
                v = $urandom;
            end
            send_event(t, c, v);
            if (!(t == T_MSC && c == C_SCAN)) begin
                done++;
            end
        end
    endtask

    initial begin
        mods_held = 8'h00;
        mods_issued = 8'h00;
        chord_done = 1'b0;
        run_len = 0;
        key_down = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_non_key_events();
        test_modifier_catch_up();
        test_meta_tap();
        test_chords();
        test_longest_chord();
        test_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct = 48;
        recv_idle_pct = 26;
        test_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(ITEMS_PER_PHASE);

        i_in_valid <= 1'b0;
        while (awaited_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("modifier_key_chord_remapper_top_test OK");
        end else begin
            $display("modifier_key_chord_remapper_top_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mkcr_pkg.sv
hdl/mkcr_datapath.sv
hdl/mkcr_ctrl.sv
hdl/modifier_key_chord_remapper_top.sv
dv/modifier_key_chord_remapper_top_test.sv
